FILE: hdl/cisum_pkg.sv
// Shared types, constants and the integer-to-double conversion for the
// compensated integer sum. No dependencies.
`default_nettype none
package cisum_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // Exponent bias plus the weight of bit 0 of each 32-bit half
  localparam logic [10:0] BIAS_LO = 11'd1023;
  localparam logic [10:0] BIAS_HI = 11'd1055;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic        has_hi;
    logic        last;
  } cisum_item_t;

  // Exact conversion of a sign and a 32-bit magnitude scaled by 2^(bias-1023)
  function automatic logic [63:0] int_to_dbl(input logic neg, input logic [31:0] m,
                                             input logic [10:0] bias);
    logic [4:0]  p;
    logic [31:0] sh;
    logic [10:0] ex;
    logic [63:0] r;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (m[i]) p = 5'(i);
    end
    sh = m << (5'd31 - p);
    ex = bias + {6'd0, p};
    if (m == 32'd0) r = {neg, 63'd0};
    else r = {neg, ex, sh[30:0], 21'd0};
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/compensated_integer_float_sum.sv
// Top level of the compensated integer sum: front end, queue and back end.
// Depends on cisum_pkg, cisum_front, cisum_fifo, cisum_back.
//
// Sums a stream of signed 64-bit integers in IEEE double precision with
// Neumaier compensation. Each integer is split into the sign-carrying low
// 32 bits of its magnitude and the remaining high part; both convert to
// double exactly. The low part is always added, the high part only when
// nonzero. On a transfer with in_last set, one result transfer follows with
// the double bits of sum plus error, and the running state returns to +0.0.
// The back end takes one part per cycle while its output is not stalled, so
// an item takes one part when its magnitude is below 2^32 and two parts
// otherwise; the running-sum adder loop sets that rate. A four-entry queue
// behind a register stage lets the front keep accepting while a result waits
// on out_ready. With the queue empty, the last part of the last element
// passes the front register, the queue, back-end stages a to d and the
// output register before out_valid rises.
`default_nettype none
module compensated_integer_float_sum (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_value,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_total_bits
);
  import cisum_pkg::*;

  logic        push_valid, push_ready, pop_valid, pop;
  cisum_item_t push_item, pop_item;

  // split and convert each transfer
  cisum_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_value, .in_last,
    .push_valid, .push_ready, .push_item
  );

  // hold split items until the back end drains them
  cisum_fifo u_fifo (
    .clk, .rst_n, .push_valid, .push_ready, .push_item,
    .pop_valid, .pop, .pop_item
  );

  // advance the compensated additions and present the total
  cisum_back u_back (
    .clk, .rst_n, .q_valid(pop_valid), .q_pop(pop), .q_item(pop_item),
    .out_valid, .out_ready, .out_total_bits
  );
endmodule
`default_nettype wire

FILE: hdl/cisum_fadd.sv
// Double-precision adder, round to nearest even, for normal numbers and zeros.
// Depends on nothing.
`default_nettype none
module cisum_fadd (
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] y
);
  logic        swap, eff_sub, stk, rnd;
  logic [63:0] big, sml;
  logic [10:0] e_big, e_sml, diff;
  logic [55:0] m_big, m_sml, al, nrm;
  logic [56:0] sum;
  logic [5:0]  lz;
  logic [12:0] ex;
  logic [53:0] mant;
  logic [51:0] frac;

  always_comb begin
    swap  = a[62:0] < b[62:0];
    big   = swap ? b : a;
    sml   = swap ? a : b;
    e_big = big[62:52];
    e_sml = sml[62:52];
    m_big = (e_big == 11'd0) ? 56'd0 : {1'b1, big[51:0], 3'b000};
    m_sml = (e_sml == 11'd0) ? 56'd0 : {1'b1, sml[51:0], 3'b000};
    diff  = e_big - e_sml;
    if (diff > 11'd55) begin
      al  = 56'd0;
      stk = |m_sml;
    end else begin
      al  = m_sml >> diff;
      stk = ((al << diff) != m_sml);
    end
    al[0]   = al[0] | stk;
    eff_sub = big[63] ^ sml[63];
    sum = eff_sub ? ({1'b0, m_big} - {1'b0, al}) : ({1'b0, m_big} + {1'b0, al});
    lz = 6'd0;
    for (int i = 0; i < 56; i++) begin
      if (sum[i]) lz = 6'(55 - i);
    end
    if (sum[56]) begin
      nrm = {sum[56:2], sum[1] | sum[0]};
      ex  = {2'b00, e_big} + 13'd1;
    end else begin
      nrm = sum[55:0] << lz;
      ex  = {2'b00, e_big} - {7'd0, lz};
    end
    rnd  = nrm[2] & (nrm[1] | nrm[0] | nrm[3]);
    mant = {1'b0, nrm[55:3]} + {53'd0, rnd};
    if (mant[53]) begin
      ex   = ex + 13'd1;
      frac = mant[52:1];
    end else begin
      frac = mant[51:0];
    end
    // exact cancellation gives +0 unless both inputs are -0
    if (sum == 57'd0) y = {big[63] & sml[63], 63'd0};
    else y = {big[63], ex[10:0], frac};
  end
endmodule
`default_nettype wire

FILE: hdl/cisum_front.sv
// Front end: accept an integer, split it into low and high parts as doubles.
// Depends on cisum_pkg.
`default_nettype none
module cisum_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [63:0]           in_value,
  input  logic                  in_last,
  output logic                  push_valid,
  input  logic                  push_ready,
  output cisum_pkg::cisum_item_t push_item
);
  import cisum_pkg::*;

  logic        f_valid_r, f_valid_nxt;
  cisum_item_t f_item_r, f_item_nxt;
  logic        neg;
  logic [63:0] mag;

  always_comb begin
    neg = in_value[63];
    mag = neg ? (64'd0 - in_value) : in_value;
    f_item_nxt.lo     = int_to_dbl(neg, mag[31:0], BIAS_LO);
    f_item_nxt.hi     = int_to_dbl(neg, mag[63:32], BIAS_HI);
    f_item_nxt.has_hi = (mag[63:32] != 32'd0);
    f_item_nxt.last   = in_last;
  end

  assign in_ready   = !f_valid_r || push_ready;
  assign push_valid = f_valid_r;
  assign push_item  = f_item_r;

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (in_ready) f_valid_nxt = in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
    if (in_valid && in_ready) f_item_r <= f_item_nxt;
  end
endmodule
`default_nettype wire

FILE: hdl/cisum_fifo.sv
// Short queue of split items between front end and back end.
// Depends on cisum_pkg.
`default_nettype none
module cisum_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  cisum_pkg::cisum_item_t push_item,
  output logic                  pop_valid,
  input  logic                  pop,
  output cisum_pkg::cisum_item_t pop_item
);
  import cisum_pkg::*;

  cisum_item_t     q_r [QDEPTH];
  logic [QAW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QAW:0]    cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign push_ready = (cnt_r != (QAW+1)'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = q_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + {{QAW{1'b0}}, do_push} - {{QAW{1'b0}}, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) q_r[wr_r] <= push_item;
  end
endmodule
`default_nettype wire

FILE: hdl/cisum_back.sv
// Back end: pipelined compensated two-sum and output register.
// Depends on cisum_pkg and cisum_fadd.
`default_nettype none
module cisum_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  cisum_pkg::cisum_item_t q_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [63:0]           out_total_bits
);
  import cisum_pkg::*;

  logic        adv, take, final_op, op_last;
  logic [63:0] x, t, big, sml, dd, f, e_nxt, total;
  logic        phase_r, s_last_unused;
  logic [63:0] s_r, e_r;
  logic        a_valid_r, a_last_r;
  logic [63:0] a_s_r, a_x_r, a_t_r;
  logic        b_valid_r, b_last_r;
  logic [63:0] b_d_r, b_sml_r, b_sum_r;
  logic        c_valid_r, c_last_r;
  logic [63:0] c_f_r, c_sum_r;
  logic        d_valid_r, d_last_r;
  logic [63:0] d_e_r, d_sum_r;
  logic        out_valid_r;
  logic [63:0] out_bits_r;

  assign adv      = !out_valid_r || out_ready;
  assign take     = adv && q_valid;
  assign final_op = phase_r || !q_item.has_hi;
  assign op_last  = final_op && q_item.last;
  assign q_pop    = take && final_op;
  assign x        = phase_r ? q_item.hi : q_item.lo;
  assign s_last_unused = 1'b0;

  // larger magnitude keeps the rounding error exactly
  always_comb begin
    if (a_s_r[62:0] >= a_x_r[62:0]) begin
      big = a_s_r;
      sml = a_x_r;
    end else begin
      big = a_x_r;
      sml = a_s_r;
    end
  end

  cisum_fadd u_sum   (.a(s_r),     .b(x),                     .y(t));
  cisum_fadd u_diff  (.a(big),     .b({~a_t_r[63], a_t_r[62:0]}), .y(dd));
  cisum_fadd u_err   (.a(b_d_r),   .b(b_sml_r),               .y(f));
  cisum_fadd u_acc   (.a(e_r),     .b(c_f_r),                 .y(e_nxt));
  cisum_fadd u_total (.a(d_sum_r), .b(d_e_r),                 .y(total));

  assign out_valid      = out_valid_r;
  assign out_total_bits = out_bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      s_r         <= 64'd0;
      e_r         <= 64'd0;
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= take;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= b_valid_r;
      d_valid_r   <= c_valid_r;
      out_valid_r <= d_valid_r && d_last_r && !s_last_unused;
      if (take) begin
        s_r     <= op_last ? 64'd0 : t;
        phase_r <= !final_op;
      end
      if (c_valid_r) e_r <= c_last_r ? 64'd0 : e_nxt;
    end
    if (adv) begin
      a_s_r    <= s_r;
      a_x_r    <= x;
      a_t_r    <= t;
      a_last_r <= op_last;
      b_d_r    <= dd;
      b_sml_r  <= sml;
      b_sum_r  <= a_t_r;
      b_last_r <= a_last_r;
      c_f_r    <= f;
      c_sum_r  <= b_sum_r;
      c_last_r <= b_last_r;
      d_e_r    <= e_nxt;
      d_sum_r  <= c_sum_r;
      d_last_r <= c_last_r;
      out_bits_r <= total;
    end
  end
endmodule
`default_nettype wire

FILE: tb/sv/tb_compensated_integer_float_sum.sv
// Self-checking testbench for compensated_integer_float_sum.
// Depends on the RTL only; predicts each array total in real arithmetic
// and checks every result transfer against it.
`timescale 1ns / 100ps
`default_nettype none

// Running Neumaier sum of the accepted elements and the queue of totals owed.
class cisum_scoreboard;
  real         acc_sum;
  real         acc_err;
  logic [63:0] totals_q[$];
  int          errors;

  function new();
    acc_sum = 0.0;
    acc_err = 0.0;
    errors  = 0;
  endfunction

  // One compensated addition into the running state
  function void neumaier_add(real x);
    real t;
    real mag_s;
    real mag_x;
    t = acc_sum + x;
    mag_s = (acc_sum < 0.0) ? -acc_sum : acc_sum;
    mag_x = (x < 0.0) ? -x : x;
    if (mag_s >= mag_x) begin
      acc_err = acc_err + ((acc_sum - t) + x);
    end else begin
      acc_err = acc_err + ((x - t) + acc_sum);
    end
    acc_sum = t;
  endfunction

  // Fold one accepted element in; owe a total when it closes the array
  function void note_input(logic [63:0] v, logic last);
    logic        neg;
    logic [63:0] mag;
    real         d;
    neg = v[63];
    mag = neg ? (64'd0 - v) : v;
    // low part: exact below 2^32, keeps the sign even when zero
    d = real'(longint'({32'd0, mag[31:0]}));
    neumaier_add(neg ? -d : d);
    if (mag[63:32] != 32'd0) begin
      d = real'(longint'({32'd0, mag[63:32]})) * 4294967296.0;
      neumaier_add(neg ? -d : d);
    end
    if (last) begin
      totals_q.push_back($realtobits(acc_sum + acc_err));
      acc_sum = 0.0;
      acc_err = 0.0;
    end
  endfunction

  function void check_result(logic [63:0] bits);
    logic [63:0] want;
    if (totals_q.size() == 0) begin
      $error("total_bits: expected none, got %h", bits);
      errors++;
    end else begin
      want = totals_q.pop_front();
      if (bits !== want) begin
        $error("total_bits: expected %h, got %h", want, bits);
        errors++;
      end
    end
  endfunction
endclass

module tb_compensated_integer_float_sum;

  localparam int MAX_GAP     = 18;
  localparam int RANDOM_ITEMS = 1530;
  localparam int HOLD_CYCLES = 400;   // long receiver stall to back the block up
  localparam int IDLE_LIMIT  = 5000;  // cycles with no transfer before giving up
  localparam int DRAIN_WAIT  = 20;    // settling wait after the last owed total

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_value = 64'd0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_total_bits;

  cisum_scoreboard sb = new();
  int  results_seen = 0;
  int  idle_cycles  = 0;
  bit  gaps_on      = 1'b1;   // toggled by the sender for burst stretches

  always #1 clk = ~clk;

  compensated_integer_float_sum dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_total_bits(out_total_bits)
  );

  // Monitor both channels on the edge; pre-edge values are what transfer.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_input(in_value, in_last);
    end
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_total_bits);
      results_seen++;
    end
  end

  // Watchdog: count cycles with no transfer on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** compensated_integer_float_sum: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, bursts with none, and one long hold-off.
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && results_seen >= 20) begin
        // hold off while the sender keeps offering, so the queue fills
        held = 1'b1;
        stall = HOLD_CYCLES;
      end else begin
        stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one element; hold it until the transfer.
  task automatic send_item(logic [63:0] v, logic last);
    int gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_value <= v;
    in_last  <= last;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Draw an element from one of several magnitude classes.
  function automatic logic [63:0] draw_value();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = 64'($signed($urandom_range(0, 200)) - 100);
      1: v = {{32{1'b0}}, 32'($urandom)};
      2: v = 64'($signed(32'($urandom)));
      3: v = {32'($urandom), 32'($urandom)};
      4: begin
        // big magnitude, mixed sign, so sums cancel and errors build up
        v = {32'($urandom), 32'($urandom)} >> $urandom_range(0, 40);
        if ($urandom_range(0, 1)) v = 64'd0 - v;
      end
      default: begin
        case ($urandom_range(0, 6))
          0: v = 64'h8000_0000_0000_0000;
          1: v = 64'h7FFF_FFFF_FFFF_FFFF;
          2: v = 64'h0000_0001_0000_0000;
          3: v = 64'hFFFF_FFFF_0000_0000;
          4: v = 64'h0000_0000_FFFF_FFFF;
          5: v = 64'hFFFF_FFFF_0000_0001;
          default: v = 64'd0;
        endcase
      end
    endcase
    return v;
  endfunction

  initial begin
    int sent;
    int len;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: single-element arrays at the extremes
    send_item(64'd0, 1'b1);                    // zero total
    send_item(64'h8000_0000_0000_0000, 1'b1);  // most negative, zero low part
    send_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_item(64'h0000_0000_FFFF_FFFF, 1'b1);
    send_item(64'h0000_0001_0000_0000, 1'b1);
    send_item(64'hFFFF_FFFF_0000_0000, 1'b1);
    // all-zero array
    send_item(64'd0, 1'b0);
    send_item(64'd0, 1'b0);
    send_item(64'd0, 1'b1);
    // cancellation: big, tiny, minus big keeps the tiny term
    send_item(64'h4000_0000_0000_0000, 1'b0);
    send_item(64'd1, 1'b0);
    send_item(64'hC000_0000_0000_0000, 1'b1);
    // extremes cancel each other
    send_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_item(64'h8000_0000_0000_0000, 1'b0);
    send_item(64'h8000_0000_0000_0001, 1'b0);
    send_item(64'h0000_0000_0000_0001, 1'b1);
    // rounding residues pile up
    send_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_item(64'h0123_4567_89AB_CDEF, 1'b1);

    // Random arrays, short ones mostly, with burst stretches
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ((sent % 150) < 20) gaps_on = 1'b0;
      else gaps_on = 1'b1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        send_item(draw_value(), (i == len - 1));
        sent++;
      end
    end
    in_valid <= 1'b0;
    gaps_on = 1'b1;

    // Drain: the watchdog bounds this wait
    while (sb.totals_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** compensated_integer_float_sum: PASSED **");
    end else begin
      $display("** compensated_integer_float_sum: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
